// ===== rtl/cdr_pkg.sv =====
// ----------------------------------------------------------------------------
// cdr_pkg
// Shared widths, register indexes, reset values and types of the contact
// debounce reporter.
// ----------------------------------------------------------------------------
package cdr_pkg;

    // Field widths
    localparam int CONTACT_W  = 16;
    localparam int MS_W       = 32;
    localparam int US_W       = 32;
    localparam int SEQ_W      = 16;
    localparam int DEBOUNCE_W = 16;
    localparam int MASK_W     = 16;

    // Stream payload widths
    localparam int IN_TDATA_W  = CONTACT_W + MS_W + US_W;
    localparam int OUT_TDATA_W = CONTACT_W + CONTACT_W + SEQ_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH_US  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MASK    = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RST = 16'd10;
    localparam logic [US_W-1:0]       REFRESH_US_RST  = 32'd100000;
    localparam logic [MASK_W-1:0]     KEY_MASK_RST    = 16'hFFFF;

    // Report decision for one scan
    typedef struct packed {
        logic             sent;
        logic [SEQ_W-1:0] sequence_num;
    } report_t;

endpackage

// ===== rtl/cdr_in_stage.sv =====
// ----------------------------------------------------------------------------
// cdr_in_stage
// Input register: captures one scan transaction and holds it until the
// processing stage takes it.
// ----------------------------------------------------------------------------
module cdr_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // raw_contacts [15:0], time_ms [47:16], time_us [79:48]
    input  logic [cdr_pkg::IN_TDATA_W-1:0] s_tdata,
    // link_up [0]
    input  logic                          s_tuser,
    input  logic                          take,
    output logic                          item_valid,
    output logic [cdr_pkg::CONTACT_W-1:0] raw_contacts,
    output logic [cdr_pkg::MS_W-1:0]      time_ms,
    output logic [cdr_pkg::US_W-1:0]      time_us,
    output logic                          link_up
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [cdr_pkg::IN_TDATA_W-1:0] data_reg;
    logic                          link_reg;
    logic                          load;

    // Accept when empty or when the held scan leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_tdata;
            link_reg <= s_tuser;
        end
    end

    assign item_valid   = valid_reg;
    assign raw_contacts = data_reg[cdr_pkg::CONTACT_W-1:0];
    assign time_ms      = data_reg[cdr_pkg::CONTACT_W +: cdr_pkg::MS_W];
    assign time_us      = data_reg[cdr_pkg::CONTACT_W + cdr_pkg::MS_W +: cdr_pkg::US_W];
    assign link_up      = link_reg;

endmodule

// ===== rtl/cdr_debounce.sv =====
// ----------------------------------------------------------------------------
// cdr_debounce
// Per-contact debounce lanes: previous raw level, change timestamp and
// debounced level, all contacts compared in parallel.
// ----------------------------------------------------------------------------
module cdr_debounce #(
    parameter int CONTACTS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic [CONTACTS-1:0]            raw,
    input  logic [cdr_pkg::MS_W-1:0]       now_ms,
    input  logic [cdr_pkg::DEBOUNCE_W-1:0] debounce_ms,
    output logic [CONTACTS-1:0]            debounced_next,
    output logic                           changed
);

    logic [CONTACTS-1:0]          prev_reg;
    logic [CONTACTS-1:0]          deb_reg;
    logic [cdr_pkg::MS_W-1:0]     time_reg  [CONTACTS];
    logic [cdr_pkg::MS_W-1:0]     time_next [CONTACTS];
    logic [CONTACTS-1:0]          flip;
    logic [cdr_pkg::MS_W-1:0]     limit;

    assign limit = cdr_pkg::MS_W'(debounce_ms);

    // One lane per contact
    for (genvar i = 0; i < CONTACTS; i++) begin : g_lane
        logic [cdr_pkg::MS_W-1:0] age;

        assign age = now_ms - time_reg[i];

        always_comb begin
            time_next[i] = time_reg[i];
            flip[i]      = 1'b0;
            if (raw[i] != prev_reg[i]) begin
                // Restart the timer on a raw edge
                time_next[i] = now_ms;
            end else if (raw[i] != deb_reg[i] && age >= limit) begin
                flip[i] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                time_reg[i] <= '0;
            end else if (advance) begin
                time_reg[i] <= time_next[i];
            end
        end
    end

    assign debounced_next = deb_reg ^ flip;
    assign changed        = |flip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            deb_reg  <= '0;
        end else if (advance) begin
            prev_reg <= raw;
            deb_reg  <= debounced_next;
        end
    end

endmodule

// ===== rtl/cdr_report.sv =====
// ----------------------------------------------------------------------------
// cdr_report
// Report scheduler: refresh timestamp, due decision and sequence counter.
// ----------------------------------------------------------------------------
module cdr_report (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic                     changed,
    input  logic                     link_up,
    input  logic [cdr_pkg::US_W-1:0] now_us,
    input  logic [cdr_pkg::US_W-1:0] refresh_us,
    output cdr_pkg::report_t         report
);

    logic [cdr_pkg::US_W-1:0]  last_reg;
    logic [cdr_pkg::US_W-1:0]  elapsed;
    logic [cdr_pkg::SEQ_W-1:0] seq_reg;
    logic [cdr_pkg::SEQ_W-1:0] seq_next;
    logic                      due;
    logic                      sent;

    // Report due on a debounced change or after the refresh interval
    assign elapsed  = now_us - last_reg;
    assign due      = changed || (elapsed >= refresh_us);
    assign sent     = due && link_up;
    assign seq_next = seq_reg + cdr_pkg::SEQ_W'(1);

    always_comb begin
        report.sent         = sent;
        report.sequence_num = sent ? seq_reg : '0;
    end

    // Move refresh time on every due report, count only sent ones
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
            seq_reg  <= '0;
        end else if (advance) begin
            if (due) begin
                last_reg <= now_us;
            end
            if (sent) begin
                seq_reg <= seq_next;
            end
        end
    end

endmodule

// ===== rtl/contact_debounce_reporter.sv =====
// ----------------------------------------------------------------------------
// contact_debounce_reporter
// Timestamp-based contact debouncer with periodic refresh reporting.
//
//  channel  | ports            | payload (lowest bit first)
//  ---------+------------------+---------------------------------------------
//  scan in  | s_tvalid/tready  | tdata: raw_contacts, time_ms, time_us
//           |                  | tuser: link_up
//  result   | m_tvalid/tready  | tdata: stable_contacts, button_bits,
//           |                  |        report_sequence; tuser: report_valid
//  config   | cfg_wr_en        | cfg_index, cfg_wdata
//
// One scan per cycle sustained while m_tready is high; a scan's result is
// registered in the input register, then in the result register.
// All per-contact state updates in the single cycle the scan leaves the
// input register, so consecutive scans see each other's updates.
// A stalled result register holds; the input register still takes one more
// scan, and s_tready drops only when both are full.
// Reset is synchronous, active low; it resets all state but not payload data.
// ----------------------------------------------------------------------------
module contact_debounce_reporter #(
    parameter int CONTACTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // raw_contacts [15:0], time_ms [47:16], time_us [79:48]
    input  logic [cdr_pkg::IN_TDATA_W-1:0]  s_tdata,
    // link_up [0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // stable_contacts [15:0], button_bits [31:16], report_sequence [47:32]
    output logic [cdr_pkg::OUT_TDATA_W-1:0] m_tdata,
    // report_valid [0]
    output logic                            m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [cdr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cdr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [cdr_pkg::DEBOUNCE_W-1:0] debounce_ms_reg;
    logic [cdr_pkg::US_W-1:0]       refresh_us_reg;
    logic [cdr_pkg::MASK_W-1:0]     key_mask_reg;

    logic                           item_valid;
    logic [cdr_pkg::CONTACT_W-1:0]  raw_contacts;
    logic [cdr_pkg::MS_W-1:0]       time_ms;
    logic [cdr_pkg::US_W-1:0]       time_us;
    logic                           link_up;
    logic                           advance;

    logic [CONTACTS-1:0]            debounced_next;
    logic                           changed;
    cdr_pkg::report_t               report;

    logic [cdr_pkg::CONTACT_W-1:0]  stable_full;
    logic                           m_valid_reg;
    logic [cdr_pkg::OUT_TDATA_W-1:0] m_data_reg;
    logic                           m_user_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ms_reg <= cdr_pkg::DEBOUNCE_MS_RST;
            refresh_us_reg  <= cdr_pkg::REFRESH_US_RST;
            key_mask_reg    <= cdr_pkg::KEY_MASK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cdr_pkg::REG_DEBOUNCE_MS: begin
                    debounce_ms_reg <= cfg_wdata[cdr_pkg::DEBOUNCE_W-1:0];
                end
                cdr_pkg::REG_REFRESH_US: begin
                    refresh_us_reg <= cfg_wdata[cdr_pkg::US_W-1:0];
                end
                cdr_pkg::REG_KEY_MASK: begin
                    key_mask_reg <= cfg_wdata[cdr_pkg::MASK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Advance a scan when the result register is free or draining
    assign advance = item_valid && (!m_valid_reg || m_tready);

    cdr_in_stage u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .take         (advance),
        .item_valid   (item_valid),
        .raw_contacts (raw_contacts),
        .time_ms      (time_ms),
        .time_us      (time_us),
        .link_up      (link_up)
    );

    cdr_debounce #(
        .CONTACTS (CONTACTS)
    ) u_debounce (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .raw            (raw_contacts[CONTACTS-1:0]),
        .now_ms         (time_ms),
        .debounce_ms    (debounce_ms_reg),
        .debounced_next (debounced_next),
        .changed        (changed)
    );

    cdr_report u_report (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .changed    (changed),
        .link_up    (link_up),
        .now_us     (time_us),
        .refresh_us (refresh_us_reg),
        .report     (report)
    );

    // Zero-extend the debounced mask to the field width
    assign stable_full = cdr_pkg::CONTACT_W'(debounced_next);

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {report.sequence_num, stable_full & key_mask_reg, stable_full};
            m_user_reg <= report.sent;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // A scan that advances always shows up as a result next cycle
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("advanced scan did not reach result register");

    // A held scan keeps its timestamps while the result side stalls
    a_hold_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !advance |=> item_valid && $stable(time_ms) && $stable(time_us))
        else $error("held scan changed while stalled");

    // Button bits are a subset of the stable contacts
    a_button_subset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg[31:16] & ~m_data_reg[15:0]) == '0))
        else $error("button bits outside stable contacts");

    // No report sent means a zero sequence field
    a_seq_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_user_reg |-> (m_data_reg[47:32] == '0))
        else $error("sequence set without a report");

    // A report is never sent while the link is down
    a_link_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !link_up |=> !m_user_reg)
        else $error("report sent with link down");
`endif

endmodule
